>>> src/bsb_pkg.sv
// Package for the band scene blitter: request and response structs, item kind
// codes and shared widths. No dependencies.
`timescale 1ns / 1ps

package bsb_pkg;

  // Signed width of the shared add/compare unit; holds x + 8*src_col + 7.
  localparam int unsigned CW = 21;

  localparam logic [2:0] BYTE_MSB  = 3'd7;
  localparam logic [3:0] MASK_BITS = 4'd8;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_RECT  = 3'd1,
    KIND_MASK  = 3'd2,
    KIND_PAL   = 3'd3,
    KIND_PWR   = 3'd4,
    KIND_READ  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [15:0]        colour;
    logic [9:0]         band_top;
    logic [7:0]         value_byte;
    logic [15:0]        src_row;
    logic [15:0]        src_col;
  } req_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        in_band;
  } rsp_t;

endpackage

>>> src/bsb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bsb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bsb_alu.sv
// Shared add/compare unit of the blitter: sum = a + b, lt = sum < lim (signed).
// Depends on bsb_pkg.
`timescale 1ns / 1ps

module bsb_alu import bsb_pkg::*; (
  input  logic signed [CW-1:0] a_i,
  input  logic signed [CW-1:0] b_i,
  input  logic signed [CW-1:0] lim_i,
  output logic signed [CW-1:0] sum_o,
  output logic                 lt_o
);

  assign sum_o = a_i + b_i;
  assign lt_o  = (sum_o < lim_i);

endmodule

>>> src/band_scene_blitter.sv
// Band scene blitter top level: request sequencer around one shared add/compare
// unit, the band store RAM and the palette RAM. Depends on bsb_pkg, bsb_alu, bsb_ram.
// Reads answer on done_o; a palette pixel writes one looked-up colour; a mask byte
// writes its set bits inside the item width; a rect fills the clipped area line by
// line; start band clears the band store (clear sweep). One request at a time, next
// taken the cycle busy drops. Reset runs the same clear sweep, busy high.
`timescale 1ns / 1ps

module band_scene_blitter import bsb_pkg::*; #(
  parameter int unsigned BAND_WIDTH      = 800,
  parameter int unsigned LINES_PER_BAND  = 16,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned DEPTH = BAND_WIDTH * LINES_PER_BAND;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(BAND_WIDTH);
  localparam int unsigned LW    = (LINES_PER_BAND > 1) ? $clog2(LINES_PER_BAND) : 1;
  localparam int unsigned PIW   = $clog2(PALETTE_ENTRIES);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_RX1    = 5'd2;
  localparam logic [4:0] S_RY1    = 5'd3;
  localparam logic [4:0] S_RY0    = 5'd4;
  localparam logic [4:0] S_RCHKX  = 5'd5;
  localparam logic [4:0] S_RCHKY  = 5'd6;
  localparam logic [4:0] S_FPIX   = 5'd7;
  localparam logic [4:0] S_FLINE  = 5'd8;
  localparam logic [4:0] S_PROW   = 5'd9;
  localparam logic [4:0] S_PSYH   = 5'd10;
  localparam logic [4:0] S_PSYL   = 5'd11;
  localparam logic [4:0] S_PCOL   = 5'd12;
  localparam logic [4:0] S_PSX    = 5'd13;
  localparam logic [4:0] S_MNB    = 5'd14;
  localparam logic [4:0] S_MBIT   = 5'd15;
  localparam logic [4:0] S_DX     = 5'd16;
  localparam logic [4:0] S_DYH    = 5'd17;
  localparam logic [4:0] S_DYL    = 5'd18;
  localparam logic [4:0] S_DADDR  = 5'd19;
  localparam logic [4:0] S_DWAIT  = 5'd20;
  localparam logic [4:0] S_DOUT   = 5'd21;

  logic [4:0]          state_q, state_d;
  req_t                req_q, req_d;
  logic [9:0]          origin_q, origin_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic signed [CW-1:0] x0_q, x0_d, x1_q, x1_d, y1_q, y1_d, cx_q, cx_d, cy_q, cy_d;
  logic [AW-1:0]       rbase_q, rbase_d;
  logic [3:0]          nb_q, nb_d;
  logic [2:0]          k_q, k_d;
  logic                inb_q, inb_d;
  logic                we_q, we_d;
  logic [AW-1:0]       waddr_q, waddr_d;
  logic [15:0]         wdata_q, wdata_d;
  logic [AW-1:0]       raddr_q, raddr_d;
  logic                done_q, done_d;
  rsp_t                rsp_q, rsp_d;

  logic signed [CW-1:0] alu_a, alu_b, alu_lim, alu_sum;
  logic                 alu_lt;

  logic signed [CW-1:0] xs, ys, ws, hs, rows, cols, col8, us, orig_s, topend, bw_s;
  logic signed [CW-1:0] dy;
  logic [LW-1:0]        line_idx;
  logic [AW-1:0]        line_base;
  logic [15:0]          st_rdata, pal_rdata;
  logic                 pal_ok, pal_we, accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign xs     = {{(CW-16){req_q.x[15]}}, req_q.x};
  assign ys     = {{(CW-16){req_q.y[15]}}, req_q.y};
  assign ws     = {{(CW-16){1'b0}}, req_q.w};
  assign hs     = {{(CW-16){1'b0}}, req_q.h};
  assign rows   = {{(CW-16){1'b0}}, req_q.src_row};
  assign cols   = {{(CW-16){1'b0}}, req_q.src_col};
  assign col8   = {{(CW-19){1'b0}}, req_q.src_col, 3'b000};
  assign us     = {{(CW-19){1'b0}}, req_q.src_col, k_q};
  assign orig_s = {{(CW-10){1'b0}}, origin_q};
  assign topend = orig_s + CW'(LINES_PER_BAND);
  assign bw_s   = CW'(BAND_WIDTH);

  assign dy        = cy_q - orig_s;
  assign line_idx  = dy[LW-1:0];
  assign line_base = AW'(line_idx) * AW'(BAND_WIDTH);

  assign pal_ok = ({1'b0, req_q.value_byte} < 9'(PALETTE_ENTRIES));
  assign pal_we = accept && (req_i.req_type == KIND_PWR)
                  && ({1'b0, req_i.value_byte} < 9'(PALETTE_ENTRIES));

  bsb_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .lim_i (alu_lim),
    .sum_o (alu_sum),
    .lt_o  (alu_lt)
  );

  bsb_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we_q),
    .waddr_i (waddr_q),
    .wdata_i (wdata_q),
    .raddr_i (raddr_q),
    .rdata_o (st_rdata)
  );

  bsb_ram #(
    .WIDTH (16),
    .DEPTH (PALETTE_ENTRIES),
    .AW    (PIW)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (req_i.value_byte[PIW-1:0]),
    .wdata_i (req_i.colour),
    .raddr_i (req_q.value_byte[PIW-1:0]),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    origin_d = origin_q;
    clr_d    = clr_q;
    x0_d     = x0_q;
    x1_d     = x1_q;
    y1_d     = y1_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    rbase_d  = rbase_q;
    nb_d     = nb_q;
    k_d      = k_q;
    inb_d    = inb_q;
    we_d     = 1'b0;
    waddr_d  = waddr_q;
    wdata_d  = wdata_q;
    raddr_d  = raddr_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    alu_a    = '0;
    alu_b    = '0;
    alu_lim  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          unique case (req_i.req_type)
            KIND_START: begin
              origin_d = req_i.band_top;
              clr_d    = '0;
              state_d  = S_CLR;
            end
            KIND_RECT: state_d = S_RX1;
            KIND_MASK: state_d = S_PROW;
            KIND_PAL:  state_d = S_PROW;
            KIND_READ: state_d = S_DX;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        we_d    = 1'b1;
        waddr_d = clr_q;
        wdata_d = '0;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      // rectangle: clip bounds, then one pixel per cycle within each line, with a line step between lines
      S_RX1: begin
        alu_a   = xs;
        alu_b   = ws;
        alu_lim = bw_s;
        x1_d    = alu_lt ? alu_sum : bw_s;
        x0_d    = xs[CW-1] ? '0 : xs;
        state_d = S_RY1;
      end
      S_RY1: begin
        alu_a   = ys;
        alu_lim = topend;
        alu_b   = hs;
        y1_d    = alu_lt ? alu_sum : topend;
        state_d = S_RY0;
      end
      S_RY0: begin
        alu_a   = ys;
        alu_lim = orig_s;
        cy_d    = alu_lt ? orig_s : ys;
        state_d = S_RCHKX;
      end
      S_RCHKX: begin
        alu_a   = x0_q;
        alu_lim = x1_q;
        state_d = alu_lt ? S_RCHKY : S_IDLE;
      end
      S_RCHKY: begin
        alu_a   = cy_q;
        alu_lim = y1_q;
        rbase_d = line_base;
        cx_d    = x0_q;
        state_d = alu_lt ? S_FPIX : S_IDLE;
      end
      S_FPIX: begin
        we_d    = 1'b1;
        waddr_d = rbase_q + AW'(cx_q[XW-1:0]);
        wdata_d = req_q.colour;
        alu_a   = cx_q;
        alu_b   = CW'(1);
        alu_lim = x1_q;
        if (alu_lt) begin
          cx_d = alu_sum;
        end else begin
          state_d = S_FLINE;
        end
      end
      S_FLINE: begin
        alu_a   = cy_q;
        alu_b   = CW'(1);
        alu_lim = y1_q;
        if (alu_lt) begin
          cy_d    = alu_sum;
          cx_d    = x0_q;
          rbase_d = rbase_q + AW'(BAND_WIDTH);
          state_d = S_FPIX;
        end else begin
          state_d = S_IDLE;
        end
      end
      // mask byte and palette pixel: line clipping shared
      S_PROW: begin
        alu_a   = rows;
        alu_lim = hs;
        state_d = alu_lt ? S_PSYH : S_IDLE;
      end
      S_PSYH: begin
        alu_a   = ys;
        alu_b   = rows;
        alu_lim = topend;
        cy_d    = alu_sum;
        state_d = alu_lt ? S_PSYL : S_IDLE;
      end
      S_PSYL: begin
        alu_a   = cy_q;
        alu_lim = orig_s;
        rbase_d = line_base;
        if (alu_lt) begin
          state_d = S_IDLE;
        end else if (req_q.req_type == KIND_MASK) begin
          state_d = S_MNB;
        end else begin
          state_d = S_PCOL;
        end
      end
      S_PCOL: begin
        alu_a   = cols;
        alu_lim = ws;
        state_d = alu_lt ? S_PSX : S_IDLE;
      end
      S_PSX: begin
        alu_a   = xs;
        alu_b   = cols;
        alu_lim = bw_s;
        we_d    = alu_lt && !alu_sum[CW-1];
        waddr_d = rbase_q + AW'(alu_sum[XW-1:0]);
        wdata_d = pal_ok ? pal_rdata : 16'h0000;
        state_d = S_IDLE;
      end
      S_MNB: begin
        alu_a   = ws;
        alu_b   = -col8;
        alu_lim = CW'(MASK_BITS);
        nb_d    = alu_lt ? alu_sum[3:0] : MASK_BITS;
        k_d     = '0;
        state_d = (alu_sum[CW-1] || alu_sum == '0) ? S_IDLE : S_MBIT;
      end
      S_MBIT: begin
        alu_a   = xs;
        alu_b   = us;
        alu_lim = bw_s;
        we_d    = req_q.value_byte[BYTE_MSB - k_q] && alu_lt && !alu_sum[CW-1];
        waddr_d = rbase_q + AW'(alu_sum[XW-1:0]);
        wdata_d = req_q.colour;
        k_d     = k_q + 1'b1;
        if (({1'b0, k_q} + 4'd1) == nb_q) begin
          state_d = S_IDLE;
        end
      end
      // read
      S_DX: begin
        alu_a   = xs;
        alu_lim = bw_s;
        inb_d   = alu_lt && !xs[CW-1];
        cy_d    = ys;
        state_d = S_DYH;
      end
      S_DYH: begin
        alu_a   = cy_q;
        alu_lim = topend;
        inb_d   = inb_q && alu_lt;
        state_d = S_DYL;
      end
      S_DYL: begin
        alu_a   = cy_q;
        alu_lim = orig_s;
        inb_d   = inb_q && !alu_lt;
        rbase_d = line_base;
        state_d = S_DADDR;
      end
      S_DADDR: begin
        raddr_d = rbase_q + AW'(req_q.x[XW-1:0]);
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        state_d = S_DOUT;
      end
      S_DOUT: begin
        done_d        = 1'b1;
        rsp_d.pixel   = inb_q ? st_rdata : 16'h0000;
        rsp_d.in_band = inb_q;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      origin_q <= '0;
      we_q     <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      origin_q <= origin_d;
      we_q     <= we_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    x0_q    <= x0_d;
    x1_q    <= x1_d;
    y1_q    <= y1_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    rbase_q <= rbase_d;
    nb_q    <= nb_d;
    k_q     <= k_d;
    inb_q   <= inb_d;
    waddr_q <= waddr_d;
    wdata_q <= wdata_d;
    raddr_q <= raddr_d;
    rsp_q   <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
